// ----- rtl/cage_pkg.sv -----
package cage_pkg;

   // Default grid capacity and cell width.
   localparam int DEF_MAX_ROWS  = 128;
   localparam int DEF_MAX_COLS  = 128;
   localparam int DEF_CELL_BITS = 8;

   // Fixed field widths of the request, response and register ports.
   localparam int OP_W       = 2;
   localparam int IDX_W      = 7;
   localparam int VAL_W      = 8;
   localparam int NS_W       = 8;
   localparam int DIM_CFG_W  = 8;
   localparam int GEN_W      = 16;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_NUM_STATES  = 2'd0,
      CSR_GRID_ROWS   = 2'd1,
      CSR_GRID_COLS   = 2'd2,
      CSR_GENERATIONS = 2'd3
   } csr_type;

   // Neighbor visiting order; a later match overrides an earlier one.
   typedef enum logic [1:0] {
      NBR_UP    = 2'd0,
      NBR_LEFT  = 2'd1,
      NBR_RIGHT = 2'd2,
      NBR_DOWN  = 2'd3
   } nbr_type;

   typedef enum logic [1:0] {
      ADDR_REQ  = 2'd0,
      ADDR_HOLD = 2'd1,
      ADDR_SELF = 2'd2,
      ADDR_NBR  = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      RSP_READ  = 2'd0,
      RSP_DONE  = 2'd1,
      RSP_ERROR = 2'd2,
      RSP_NONE  = 2'd3
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_RUN_START,
      ST_CELL_SELF,
      ST_CELL_OLD,
      ST_NBR_CHECK,
      ST_NBR_EVAL,
      ST_MOD_WAIT,
      ST_CELL_WRITE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_RUN_DONE
   } state_type;

   typedef struct packed {
      logic         grid_wr;
      logic         copy_wr;
      logic         next_wr;
      addr_sel_type addr_sel;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
      logic         cnt_clear;
      logic         cnt_step;
      logic         k_clear;
      logic         k_step;
      logic         old_cap;
      logic         nbr_apply;
      logic         mod_start;
      logic         chg_clear;
      logic         gen_clear;
      logic         gen_step;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   out_free;
      logic   nbr_ok;
      logic   k_last;
      logic   cell_last;
      logic   fast_ok;
      logic   mod_done;
      logic   changed_any;
      logic   gen_last;
      logic   run_empty;
   } stat_type;

endpackage

// ----- rtl/cage_mod.sv -----
module cage_mod #(
   parameter int X_W = 9
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [X_W-1:0] dividend,
   input  logic [X_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [X_W-1:0] remainder
);
   // Restoring remainder, one dividend bit per cycle, MSB first.
   localparam int CNT_W = $clog2(X_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [X_W-1:0]   rem_ff, rem_in;
   logic [X_W-1:0]   sh_ff, sh_in;
   logic [X_W-1:0]   div_ff, div_in;
   logic [X_W:0]     trial;

   always_comb begin
      trial   = {rem_ff, sh_ff[X_W-1]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(X_W);
         rem_in = '0;
         sh_in  = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = X_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[X_W-1:0];
         end
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      div_ff <= div_in;
   end

   assign busy      = run_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/cage_dp.sv -----
module cage_dp #(
   parameter int MAX_ROWS  = cage_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = cage_pkg::DEF_MAX_COLS,
   parameter int CELL_BITS = cage_pkg::DEF_CELL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cage_pkg::OP_W-1:0]         req_opcode,
   input  logic [cage_pkg::IDX_W-1:0]        req_row_index,
   input  logic [cage_pkg::IDX_W-1:0]        req_col_index,
   input  logic [cage_pkg::VAL_W-1:0]        req_cell_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cage_pkg::VAL_W-1:0]        rsp_cell_out,
   output logic                              rsp_done_res,
   output logic                              rsp_error,
   input  logic                              csr_write,
   input  cage_pkg::csr_type                 csr_index,
   input  logic [cage_pkg::CSR_DATA_W-1:0]   csr_data,
   input  cage_pkg::cmd_type                 cmd,
   output cage_pkg::stat_type                stat
);
   import cage_pkg::*;

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int RC_W   = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
   localparam int DIM_W  = (RC_W > DIM_CFG_W) ? RC_W : DIM_CFG_W;
   localparam int X_W    = (CELL_BITS > NS_W) ? CELL_BITS + 1 : NS_W + 1;

   // Configuration registers.
   logic [NS_W-1:0]      ns_ff, ns_in;
   logic [DIM_CFG_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [DIM_CFG_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [GEN_W-1:0]     gens_ff, gens_in;

   always_comb begin
      ns_in       = ns_ff;
      rows_cfg_in = rows_cfg_ff;
      cols_cfg_in = cols_cfg_ff;
      gens_in     = gens_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_STATES:  ns_in       = csr_data[NS_W-1:0];
            CSR_GRID_ROWS:   rows_cfg_in = csr_data[DIM_CFG_W-1:0];
            CSR_GRID_COLS:   cols_cfg_in = csr_data[DIM_CFG_W-1:0];
            CSR_GENERATIONS: gens_in     = csr_data[GEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff       <= NS_W'(2);
         rows_cfg_ff <= DIM_CFG_W'(1);
         cols_cfg_ff <= DIM_CFG_W'(1);
         gens_ff     <= '0;
      end else begin
         ns_ff       <= ns_in;
         rows_cfg_ff <= rows_cfg_in;
         cols_cfg_ff <= cols_cfg_in;
         gens_ff     <= gens_in;
      end
   end

   // Grid size in use, clipped to the storage.
   logic [DIM_W-1:0] rows_lim;
   logic [DIM_W-1:0] cols_lim;

   assign rows_lim = (DIM_W'(rows_cfg_ff) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                              : DIM_W'(rows_cfg_ff);
   assign cols_lim = (DIM_W'(cols_cfg_ff) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                              : DIM_W'(cols_cfg_ff);

   // Request address decode.
   logic [DIM_W-1:0]  req_row_ext;
   logic [DIM_W-1:0]  req_col_ext;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] hold_addr_ff;

   assign req_row_ext = DIM_W'(req_row_index);
   assign req_col_ext = DIM_W'(req_col_index);
   assign req_addr    = {req_row_ext[ROW_W-1:0], req_col_ext[COL_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.addr_sel == ADDR_REQ) begin
         hold_addr_ff <= req_addr;
      end
   end

   // Cell walk counters and neighbor pointer.
   logic [ROW_W-1:0] r_ff, r_in;
   logic [COL_W-1:0] c_ff, c_in;
   nbr_type          k_ff, k_in;
   logic             col_last;
   logic             row_last;

   assign col_last = (DIM_W'(c_ff) + DIM_W'(1)) == cols_lim;
   assign row_last = (DIM_W'(r_ff) + DIM_W'(1)) == rows_lim;

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (cmd.cnt_clear) begin
         r_in = '0;
         c_in = '0;
      end else if (cmd.cnt_step) begin
         if (col_last) begin
            c_in = '0;
            r_in = r_ff + ROW_W'(1);
         end else begin
            c_in = c_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.k_clear) begin
         k_in = NBR_UP;
      end else if (cmd.k_step) begin
         unique case (k_ff)
            NBR_UP:    k_in = NBR_LEFT;
            NBR_LEFT:  k_in = NBR_RIGHT;
            NBR_RIGHT: k_in = NBR_DOWN;
            NBR_DOWN:  k_in = NBR_DOWN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
         c_ff <= '0;
         k_ff <= NBR_UP;
      end else begin
         r_ff <= r_in;
         c_ff <= c_in;
         k_ff <= k_in;
      end
   end

   logic [ADDR_W-1:0] self_addr;
   logic [ADDR_W-1:0] nbr_addr;
   logic              nbr_ok;

   assign self_addr = {r_ff, c_ff};

   always_comb begin
      unique case (k_ff)
         NBR_UP: begin
            nbr_addr = {r_ff - ROW_W'(1), c_ff};
            nbr_ok   = (r_ff != '0);
         end
         NBR_LEFT: begin
            nbr_addr = {r_ff, c_ff - COL_W'(1)};
            nbr_ok   = (c_ff != '0);
         end
         NBR_RIGHT: begin
            nbr_addr = {r_ff, c_ff + COL_W'(1)};
            nbr_ok   = !col_last;
         end
         NBR_DOWN: begin
            nbr_addr = {r_ff + ROW_W'(1), c_ff};
            nbr_ok   = !row_last;
         end
      endcase
   end

   // Grid and next-generation memories.
   logic [CELL_BITS-1:0] grid_mem [DEPTH];
   logic [CELL_BITS-1:0] next_mem [DEPTH];
   logic [CELL_BITS-1:0] grid_rd_ff;
   logic [CELL_BITS-1:0] next_rd_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [CELL_BITS-1:0] wr_data;
   logic                 grid_we;
   logic [CELL_BITS-1:0] old_ff, old_in;
   logic [CELL_BITS-1:0] nv_ff, nv_in;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_REQ:  rd_addr = req_addr;
         ADDR_HOLD: rd_addr = hold_addr_ff;
         ADDR_SELF: rd_addr = self_addr;
         ADDR_NBR:  rd_addr = nbr_addr;
      endcase
   end

   assign grid_we = cmd.grid_wr | cmd.copy_wr;
   assign wr_addr = cmd.grid_wr ? req_addr : self_addr;
   assign wr_data = cmd.grid_wr ? CELL_BITS'(req_cell_in) : next_rd_ff;

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      grid_rd_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.next_wr) begin
         next_mem[self_addr] <= nv_ff;
      end
      next_rd_ff <= next_mem[self_addr];
   end

   // Successor test: (v + 1) mod n == old.
   logic [X_W-1:0] succ_x;
   logic [X_W-1:0] n_eff;
   logic [X_W:0]   two_n;
   logic           lt_n;
   logic           fast_ok;
   logic [X_W-1:0] fast_rem;
   logic [X_W-1:0] mod_rem;
   logic           mod_busy;
   logic           mod_done;
   logic [X_W-1:0] rem_sel;
   logic           match;

   assign succ_x   = X_W'(grid_rd_ff) + X_W'(1);
   assign n_eff    = (ns_ff == '0) ? (X_W'(1) << NS_W) : X_W'(ns_ff);
   assign two_n    = (X_W + 1)'(n_eff) << 1;
   assign lt_n     = succ_x < n_eff;
   assign fast_ok  = (X_W + 1)'(succ_x) < two_n;
   assign fast_rem = lt_n ? succ_x : succ_x - n_eff;
   assign rem_sel  = fast_ok ? fast_rem : mod_rem;
   assign match    = rem_sel == X_W'(old_ff);

   cage_mod #(
      .X_W (X_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (succ_x),
      .divisor   (n_eff),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      old_in = old_ff;
      nv_in  = nv_ff;
      if (cmd.old_cap) begin
         old_in = grid_rd_ff;
         nv_in  = grid_rd_ff;
      end else if (cmd.nbr_apply && match) begin
         nv_in = grid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;
      nv_ff  <= nv_in;
   end

   // Change tracking and generation count.
   logic             chg_ff, chg_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic             cell_diff;

   assign cell_diff = nv_ff != old_ff;

   always_comb begin
      chg_in = chg_ff;
      if (cmd.chg_clear) begin
         chg_in = 1'b0;
      end else if (cmd.next_wr && cell_diff) begin
         chg_in = 1'b1;
      end
      gen_in = gen_ff;
      if (cmd.gen_clear) begin
         gen_in = '0;
      end else if (cmd.gen_step) begin
         gen_in = gen_ff + GEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_ff <= 1'b0;
         gen_ff <= '0;
      end else begin
         chg_ff <= chg_in;
         gen_ff <= gen_in;
      end
   end

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] cell_ff, cell_in;
   logic             done_ff, done_in;
   logic             err_ff, err_in;
   logic             out_free;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_comb begin
      cell_in = cell_ff;
      done_in = done_ff;
      err_in  = err_ff;
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_kind)
            RSP_READ: begin
               cell_in = VAL_W'(grid_rd_ff);
               done_in = 1'b1;
               err_in  = 1'b0;
            end
            RSP_DONE: begin
               cell_in = '0;
               done_in = 1'b1;
               err_in  = 1'b0;
            end
            RSP_ERROR: begin
               cell_in = '0;
               done_in = 1'b0;
               err_in  = 1'b1;
            end
            RSP_NONE: begin
               cell_in = '0;
               done_in = 1'b0;
               err_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = cell_ff;
   assign rsp_done_res = done_ff;
   assign rsp_error    = err_ff;

   // Status toward the controller.
   always_comb begin
      stat.op          = op_type'(req_opcode);
      stat.in_range    = (req_row_ext < rows_lim) && (req_col_ext < cols_lim);
      stat.out_free    = out_free;
      stat.nbr_ok      = nbr_ok;
      stat.k_last      = (k_ff == NBR_DOWN);
      stat.cell_last   = col_last && row_last;
      stat.fast_ok     = fast_ok;
      stat.mod_done    = mod_done;
      stat.changed_any = chg_ff | cell_diff;
      stat.gen_last    = ((GEN_W + 1)'(gen_ff) + (GEN_W + 1)'(1)) == (GEN_W + 1)'(gens_ff);
      stat.run_empty   = (gens_ff == '0) || (rows_lim == '0) || (cols_lim == '0);
   end

   // A new response must never overwrite one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("response loaded while the output register is occupied");

   // Item writes and copy-back writes share the grid write port.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.grid_wr, cmd.copy_wr}))
      else $error("two writers on the grid write port");

   // The remainder unit is started only when it is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.mod_start |-> !mod_busy)
      else $error("remainder unit restarted while busy");

   // A neighbor value is applied only for a neighbor inside the grid.
   assert property (@(posedge clock) disable iff (reset)
      cmd.nbr_apply |-> nbr_ok)
      else $error("off-grid neighbor applied");

endmodule

// ----- rtl/cage_ctrl.sv -----
module cage_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cage_pkg::stat_type stat,
   output cage_pkg::cmd_type  cmd
);
   import cage_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = (state_ff == ST_IDLE) && req_valid && stat.out_free;
   assign req_stall = !((state_ff == ST_IDLE) && stat.out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (stat.op)
                  OP_READ: begin
                     if (stat.in_range) begin
                        state_in = ST_RD_WAIT;
                     end
                  end
                  OP_RUN:   state_in = ST_RUN_START;
                  OP_WRITE: state_in = ST_IDLE;
                  OP_NONE:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_WAIT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN_START: begin
            state_in = stat.run_empty ? ST_RUN_DONE : ST_CELL_SELF;
         end
         ST_CELL_SELF: state_in = ST_CELL_OLD;
         ST_CELL_OLD:  state_in = ST_NBR_CHECK;
         ST_NBR_CHECK: begin
            if (stat.nbr_ok) begin
               state_in = ST_NBR_EVAL;
            end else if (stat.k_last) begin
               state_in = ST_CELL_WRITE;
            end
         end
         ST_NBR_EVAL: begin
            if (!stat.fast_ok) begin
               state_in = ST_MOD_WAIT;
            end else begin
               state_in = stat.k_last ? ST_CELL_WRITE : ST_NBR_CHECK;
            end
         end
         ST_MOD_WAIT: begin
            if (stat.mod_done) begin
               state_in = stat.k_last ? ST_CELL_WRITE : ST_NBR_CHECK;
            end
         end
         ST_CELL_WRITE: begin
            if (!stat.cell_last) begin
               state_in = ST_CELL_SELF;
            end else begin
               state_in = stat.changed_any ? ST_COPY_RD : ST_RUN_DONE;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (!stat.cell_last) begin
               state_in = ST_COPY_RD;
            end else begin
               state_in = stat.gen_last ? ST_RUN_DONE : ST_CELL_SELF;
            end
         end
         ST_RUN_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = ADDR_SELF;
      cmd.rsp_kind = RSP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.addr_sel = ADDR_REQ;
            if (accept) begin
               unique case (stat.op)
                  OP_WRITE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.in_range) begin
                        cmd.grid_wr  = 1'b1;
                        cmd.rsp_kind = RSP_DONE;
                     end else begin
                        cmd.rsp_kind = RSP_ERROR;
                     end
                  end
                  OP_READ: begin
                     if (!stat.in_range) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = RSP_ERROR;
                     end
                  end
                  OP_RUN: begin
                     cmd.cnt_clear = 1'b1;
                     cmd.k_clear   = 1'b1;
                     cmd.chg_clear = 1'b1;
                     cmd.gen_clear = 1'b1;
                  end
                  OP_NONE: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RSP_NONE;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.addr_sel = ADDR_HOLD;
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_READ;
            end
         end
         ST_RUN_START: begin
         end
         ST_CELL_SELF: begin
         end
         ST_CELL_OLD: begin
            cmd.old_cap = 1'b1;
            cmd.k_clear = 1'b1;
         end
         ST_NBR_CHECK: begin
            cmd.addr_sel = ADDR_NBR;
            if (!stat.nbr_ok && !stat.k_last) begin
               cmd.k_step = 1'b1;
            end
         end
         ST_NBR_EVAL: begin
            cmd.addr_sel = ADDR_NBR;
            if (stat.fast_ok) begin
               cmd.nbr_apply = 1'b1;
               cmd.k_step    = !stat.k_last;
            end else begin
               cmd.mod_start = 1'b1;
            end
         end
         ST_MOD_WAIT: begin
            cmd.addr_sel = ADDR_NBR;
            if (stat.mod_done) begin
               cmd.nbr_apply = 1'b1;
               cmd.k_step    = !stat.k_last;
            end
         end
         ST_CELL_WRITE: begin
            cmd.next_wr = 1'b1;
            if (stat.cell_last) begin
               cmd.cnt_clear = stat.changed_any;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_COPY_RD: begin
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (stat.cell_last) begin
               cmd.gen_step = 1'b1;
               if (!stat.gen_last) begin
                  cmd.cnt_clear = 1'b1;
                  cmd.chg_clear = 1'b1;
               end
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_RUN_DONE: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_DONE;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/cyclic_automaton_grid_engine.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_opcode, req_row_index, req_col_index, req_cell_in
// rsp       out        rsp_valid/rsp_stall  rsp_cell_out, rsp_done_res, rsp_error
// csr       in         csr_write            csr_index, csr_data
//
// A write, an off-grid access or an unused opcode is answered from ST_IDLE, an in-grid read from
// ST_RD_WAIT. A run starts in ST_RUN_START, ends in ST_RUN_DONE, and per generation each cell takes
// ST_CELL_SELF, ST_CELL_OLD, ST_NBR_CHECK and ST_NBR_EVAL per in-grid neighbor, ST_NBR_CHECK per
// off-grid one and ST_CELL_WRITE, later ST_COPY_RD and ST_COPY_WR to copy back. A neighbor value
// above 2*num_states-2 waits on the remainder unit; an unchanged generation ends the run at once.
// Reset is synchronous and active high; it resets settings and control, the grid stays unset.
// A stalled response holds in the output register and the next request waits until it drains.

module cyclic_automaton_grid_engine #(
   parameter int MAX_ROWS  = cage_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = cage_pkg::DEF_MAX_COLS,
   parameter int CELL_BITS = cage_pkg::DEF_CELL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cage_pkg::OP_W-1:0]       req_opcode,
   input  logic [cage_pkg::IDX_W-1:0]      req_row_index,
   input  logic [cage_pkg::IDX_W-1:0]      req_col_index,
   input  logic [cage_pkg::VAL_W-1:0]      req_cell_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cage_pkg::VAL_W-1:0]      rsp_cell_out,
   output logic                            rsp_done_res,
   output logic                            rsp_error,
   input  logic                            csr_write,
   input  cage_pkg::csr_type               csr_index,
   input  logic [cage_pkg::CSR_DATA_W-1:0] csr_data
);
   import cage_pkg::*;

   // The controller sequences each request; the datapath holds the configuration registers,
   // both cell memories, the walk counters, the successor test and the response register.
   cmd_type  cmd;
   stat_type stat;

   cage_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The grid memory always holds the current generation. During a run each new cell value
   // goes to the next-generation memory, and once every cell is done the grid in use is copied back
   // if any cell changed, so cells outside the grid in use are never disturbed.
   cage_dp #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .CELL_BITS (CELL_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_opcode),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_cell_in   (req_cell_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_out  (rsp_cell_out),
      .rsp_done_res  (rsp_done_res),
      .rsp_error     (rsp_error),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule
